@@ design/assert_macros.svh @@
// Assertion macros for the RTL, included by dtq_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dtq_pkg.sv @@
`default_nettype none
package dtq_pkg;
    localparam int DEFAULT_CAPACITY = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CTX_W = 32;
    localparam int DL_W = 48;
    localparam int ORD_W = 16;

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_POLL = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;

    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_STOPPED = 3'd1;
    localparam logic [2:0] KIND_FULL    = 3'd2;
    localparam logic [2:0] KIND_FIRED   = 3'd3;
    localparam logic [2:0] KIND_NONE    = 3'd4;
    localparam logic [2:0] KIND_STOPACK = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic do_add;
        logic do_stop;
        logic scan_start;
        logic scan_step;
        logic grp_start;
        logic grp_step;
        logic fire;
    } dtq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic any;
        logic due;
        logic grp_done;
        logic grp_found;
        logic grp_single;
        logic full;
        logic accepting;
    } dtq_stat_t;
endpackage
`default_nettype wire

@@ design/dtq_datapath.sv @@
`default_nettype none
module dtq_datapath import dtq_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dtq_cmd_t         cmd,
    output dtq_stat_t             stat,
    input  wire logic [1:0]       req_type,
    input  wire logic [CTX_W-1:0] entry_context,
    input  wire logic [DL_W-1:0]  deadline_ms,
    input  wire logic [DL_W-1:0]  now_ms,
    output logic [CTX_W-1:0]      fire_ctx,
    output logic [DL_W-1:0]       fire_key,
    output logic [1:0]            req_held
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DL_W-1:0]  dl_mem [CAPACITY];
    logic [CTX_W-1:0] ctx_mem [CAPACITY];
    logic [ORD_W-1:0] ord_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [ORD_W-1:0] seq_reg;
    logic accepting_reg;

    logic [1:0]       req_reg;
    logic [CTX_W-1:0] ctx_in_reg;
    logic [DL_W-1:0]  dl_in_reg;
    logic [DL_W-1:0]  now_reg;

    logic [CW-1:0]    idx_reg;
    logic             any_reg;
    logic [DL_W-1:0]  key_reg;
    logic             found_reg;
    logic [CW-1:0]    match_reg;
    logic [IW-1:0]    pick_reg;
    logic [ORD_W-1:0] best_reg;

    logic [IW-1:0]    free_idx;
    logic             free_any;
    logic [IW-1:0]    cur;
    logic [ORD_W-1:0] age;

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    assign cur = idx_reg[IW-1:0];
    assign age = seq_reg - ord_mem[cur];

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg    <= req_type;
            ctx_in_reg <= entry_context;
            dl_in_reg  <= deadline_ms;
            now_reg    <= now_ms;
        end
        if (cmd.do_add && accepting_reg && free_any) begin
            dl_mem[free_idx]  <= dl_in_reg;
            ctx_mem[free_idx] <= ctx_in_reg;
            ord_mem[free_idx] <= seq_reg;
        end
        if (cmd.scan_step && valid_reg[cur] && (!any_reg || dl_mem[cur] < key_reg)) begin
            key_reg <= dl_mem[cur];
        end
        if (cmd.grp_step && valid_reg[cur] && dl_mem[cur] == key_reg
            && (!found_reg || age > best_reg)) begin
            pick_reg <= cur;
            best_reg <= age;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            seq_reg       <= '0;
            accepting_reg <= 1'b1;
            idx_reg       <= '0;
            any_reg       <= 1'b0;
            found_reg     <= 1'b0;
            match_reg     <= '0;
        end else begin
            if (cmd.do_add && accepting_reg && free_any) begin
                valid_reg[free_idx] <= 1'b1;
                seq_reg <= seq_reg + 1'b1;
            end
            if (cmd.do_stop) accepting_reg <= 1'b0;
            if (cmd.scan_start || cmd.grp_start) begin
                idx_reg   <= '0;
                any_reg   <= cmd.scan_start ? 1'b0 : any_reg;
                found_reg <= 1'b0;
                match_reg <= '0;
            end
            if (cmd.scan_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (valid_reg[cur]) any_reg <= 1'b1;
            end
            if (cmd.grp_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (valid_reg[cur] && dl_mem[cur] == key_reg) begin
                    found_reg <= 1'b1;
                    match_reg <= match_reg + 1'b1;
                end
            end
            if (cmd.fire) valid_reg[pick_reg] <= 1'b0;
        end
    end

    assign stat.scan_done  = (idx_reg == CW'(CAPACITY));
    assign stat.grp_done   = (idx_reg == CW'(CAPACITY));
    assign stat.any        = any_reg;
    assign stat.due        = !accepting_reg || key_reg <= now_reg;
    assign stat.grp_found  = found_reg;
    assign stat.grp_single = (match_reg == CW'(1));
    assign stat.full       = !free_any;
    assign stat.accepting  = accepting_reg;

    assign fire_ctx = ctx_mem[pick_reg];
    assign fire_key = key_reg;
    assign req_held = req_reg;
endmodule
`default_nettype wire

@@ design/dtq_ctrl.sv @@
`default_nettype none
module dtq_ctrl import dtq_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_result_kind,
    output logic [CTX_W-1:0]      m_fired_context,
    output logic [DL_W-1:0]       m_fired_deadline,
    output logic                  m_last_of_batch,
    output dtq_cmd_t              cmd,
    input  wire dtq_stat_t        stat,
    input  wire logic [1:0]       req_held,
    input  wire logic [CTX_W-1:0] fire_ctx,
    input  wire logic [DL_W-1:0]  fire_key
);
    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_GRP  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam int NW = $clog2(MAX_RESULTS + 1);

    logic [2:0]  state_reg, state_next;
    logic [NW-1:0] cnt_reg;
    logic        ovalid_reg;
    logic [2:0]  kind_reg;
    logic [CTX_W-1:0] octx_reg;
    logic [DL_W-1:0]  odl_reg;
    logic        olast_reg;
    logic        out_free;
    logic        fire_last;
    logic        dec_out;
    logic        none_out;
    logic        load_out;

    assign out_free  = !ovalid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign fire_last = stat.grp_single || (cnt_reg == NW'(MAX_RESULTS - 1));
    assign dec_out   = (state_reg == ST_DEC) && (req_held != REQ_POLL) && out_free;
    assign none_out  = (state_reg == ST_OUT) && out_free && (cnt_reg == '0);
    assign load_out  = cmd.fire || dec_out || none_out;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (req_held == REQ_POLL) begin
                    cmd.scan_start = 1'b1;
                    state_next = ST_SCAN;
                end else if (out_free) begin
                    cmd.do_add  = (req_held == REQ_ADD);
                    cmd.do_stop = (req_held == REQ_STOP);
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    if (!stat.any || !stat.due) begin
                        state_next = ST_OUT;
                    end else begin
                        cmd.grp_start = 1'b1;
                        state_next = ST_GRP;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_GRP: begin
                if (stat.grp_done) begin
                    state_next = stat.grp_found ? ST_EMIT : ST_OUT;
                end else begin
                    cmd.grp_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.fire = 1'b1;
                    if (fire_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.grp_start = 1'b1;
                        state_next = ST_GRP;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) ovalid_reg <= 1'b1;
            else if (m_ready) ovalid_reg <= 1'b0;
            if (cmd.scan_start) cnt_reg <= '0;
            else if (cmd.fire) cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fire) begin
            kind_reg  <= KIND_FIRED;
            octx_reg  <= fire_ctx;
            odl_reg   <= fire_key;
            olast_reg <= fire_last;
        end else if (dec_out) begin
            olast_reg <= 1'b1;
            octx_reg  <= '0;
            odl_reg   <= '0;
            unique case (req_held)
                REQ_ADD:  kind_reg <= !stat.accepting ? KIND_STOPPED :
                                      stat.full ? KIND_FULL : KIND_ADDED;
                REQ_STOP: kind_reg <= KIND_STOPACK;
                default:  kind_reg <= KIND_NONE;
            endcase
        end else if (none_out) begin
            kind_reg  <= KIND_NONE;
            octx_reg  <= '0;
            odl_reg   <= '0;
            olast_reg <= 1'b1;
        end
    end

    assign m_valid          = ovalid_reg;
    assign m_result_kind    = kind_reg;
    assign m_fired_context  = octx_reg;
    assign m_fired_deadline = odl_reg;
    assign m_last_of_batch  = olast_reg;

    `ASSERT_IMPL(a_fire_in_emit, aclk, aresetn, cmd.fire, state_reg == ST_EMIT, "fire outside emit")
    `ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE, "ready while busy")
    `ASSERT_NEXT(a_fire_valid, aclk, aresetn, cmd.fire, m_valid && m_result_kind == KIND_FIRED, "fire lost")
endmodule
`default_nettype wire

@@ design/deadline_timer_queue.sv @@
// deadline_timer_queue: deadline-ordered timer table.
// Input channel s_*: req_type selects add, poll or stop; entry_context and
// deadline_ms go with an add, now_ms with a poll. Accepted when s_valid and
// s_ready are both high; s_ready is high only while the block is idle.
// Result channel m_*: one item per add or stop, one nothing-due item for a poll
// with nothing due or for an unused req_type, else one fired item per entry of
// the earliest group (at most MAX_RESULTS), oldest first, m_last_of_batch on the
// final item of each request. An add or stop result is loaded from the decode
// state. A poll scans all CAPACITY slots for the minimum deadline; if it is due
// (or the queue is stopped), a group pass over the slots picks the oldest entry
// with that deadline, fired once the result register is free, and another group
// pass follows for each further fired item. The next request can be accepted in
// the cycle after the final item is loaded.
// The result register holds one item; while m_ready is low the block waits
// with the item held stable. Reset empties the table and restarts the queue.
`default_nettype none
module deadline_timer_queue import dtq_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_req_type,
    input  wire logic [CTX_W-1:0] s_entry_context,
    input  wire logic [DL_W-1:0]  s_deadline_ms,
    input  wire logic [DL_W-1:0]  s_now_ms,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_result_kind,
    output logic [CTX_W-1:0]      m_fired_context,
    output logic [DL_W-1:0]       m_fired_deadline,
    output logic                  m_last_of_batch
);
    dtq_cmd_t         cmd;
    dtq_stat_t        stat;
    logic [CTX_W-1:0] fire_ctx;
    logic [DL_W-1:0]  fire_key;
    logic [1:0]       req_held;

    dtq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .req_type(s_req_type), .entry_context(s_entry_context),
        .deadline_ms(s_deadline_ms), .now_ms(s_now_ms),
        .fire_ctx, .fire_key, .req_held
    );

    dtq_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .m_result_kind, .m_fired_context, .m_fired_deadline, .m_last_of_batch,
        .cmd, .stat, .req_held, .fire_ctx, .fire_key
    );
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
module tb_top;
    import dtq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 5000000;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};

    typedef struct {
        logic [1:0]       req;
        logic [CTX_W-1:0] ctx;
        logic [DL_W-1:0]  dl;
        logic [DL_W-1:0]  now;
        bit               drain_first;
    } req_item_t;

    typedef struct {
        logic [2:0]       kind;
        logic [CTX_W-1:0] ctx;
        logic [DL_W-1:0]  dl;
        logic             last;
    } timer_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [CTX_W-1:0] s_entry_context = '0;
    logic [DL_W-1:0] s_deadline_ms = '0;
    logic [DL_W-1:0] s_now_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_result_kind;
    logic [CTX_W-1:0] m_fired_context;
    logic [DL_W-1:0] m_fired_deadline;
    logic m_last_of_batch;

    deadline_timer_queue #(.CAPACITY(CAP)) dut (.*);

    req_item_t pending_reqs[$];
    timer_result_t expected_results[$];

    logic [DL_W-1:0] tbl_deadline[CAP];
    logic [CTX_W-1:0] tbl_context[CAP];
    bit tbl_used[CAP];
    logic [ORD_W-1:0] tbl_stamp[CAP];
    logic [ORD_W-1:0] next_stamp = '0;
    bit running = 1'b1;

    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int fired_seen = 0;
    int cycles = 0;
    bit hold_done = 1'b0;
    logic [DL_W-1:0] dl_pool[8];

    initial forever #5 aclk = ~aclk;

    function automatic void push_result(logic [2:0] k, logic [CTX_W-1:0] c,
                                        logic [DL_W-1:0] d, logic l);
        timer_result_t r;
        r.kind = k; r.ctx = c; r.dl = d; r.last = l;
        expected_results = {expected_results, r};
    endfunction

    function automatic void predict_timers(req_item_t it);
        int pick;
        int n;
        bit any;
        bit placed;
        logic [DL_W-1:0] key;
        logic [ORD_W-1:0] age;
        logic [ORD_W-1:0] best;
        n = 0; any = 0; key = '0; placed = 0; best = '0;
        case (it.req)
            REQ_ADD: begin
                if (!running) begin
                    push_result(KIND_STOPPED, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < CAP; i++) begin
                        if (!placed && !tbl_used[i]) begin
                            tbl_used[i] = 1;
                            tbl_deadline[i] = it.dl;
                            tbl_context[i] = it.ctx;
                            tbl_stamp[i] = next_stamp;
                            next_stamp = next_stamp + 1'b1;
                            placed = 1;
                        end
                    end
                    push_result(placed ? KIND_ADDED : KIND_FULL, '0, '0, 1'b1);
                end
            end
            REQ_POLL: begin
                for (int i = 0; i < CAP; i++) begin
                    if (tbl_used[i] && (!any || tbl_deadline[i] < key)) begin
                        key = tbl_deadline[i];
                        any = 1;
                    end
                end
                if (!any || (running && key > it.now)) begin
                    push_result(KIND_NONE, '0, '0, 1'b1);
                end else begin
                    pick = 0;
                    while (n < MAX_RESULTS && pick >= 0) begin
                        pick = -1;
                        for (int i = 0; i < CAP; i++) begin
                            if (tbl_used[i] && tbl_deadline[i] == key) begin
                                age = next_stamp - tbl_stamp[i];
                                if (pick < 0 || age > best) begin
                                    pick = i;
                                    best = age;
                                end
                            end
                        end
                        if (pick >= 0) begin
                            tbl_used[pick] = 0;
                            push_result(KIND_FIRED, tbl_context[pick], key, 1'b0);
                            n++;
                        end
                    end
                    expected_results[$].last = 1'b1;
                end
            end
            REQ_STOP: begin
                running = 0;
                push_result(KIND_STOPACK, '0, '0, 1'b1);
            end
            default: push_result(KIND_NONE, '0, '0, 1'b1);
        endcase
    endfunction

    function automatic logic [DL_W-1:0] rand_wide();
        return DL_W'({$urandom, $urandom});
    endfunction

    function automatic logic [DL_W-1:0] rand_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return dl_pool[$urandom_range(0, 7)];
        if (r == 7) return DL_MAX;
        return rand_wide();
    endfunction

    function automatic void queue_req(logic [1:0] rq, logic [CTX_W-1:0] c,
                                      logic [DL_W-1:0] d, logic [DL_W-1:0] t, bit df);
        req_item_t it;
        it.req = rq; it.ctx = c; it.dl = d; it.now = t; it.drain_first = df;
        pending_reqs = {pending_reqs, it};
    endfunction

    // driver
    always @(posedge aclk) begin
        req_item_t it;
        logic v;
        int gap;
        bit tail;
        static int idle_left = 0;
        v = s_valid;
        tail = pending_reqs.size() < 60;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_timers('{s_req_type, s_entry_context, s_deadline_ms, s_now_ms, 0});
                accepted++;
                v = 1'b0;
            end
            if (!v) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (pending_reqs.size() > 0) begin
                    if (!pending_reqs[0].drain_first || expected_results.size() == 0) begin
                        it = pending_reqs.pop_front();
                        s_req_type <= it.req;
                        s_entry_context <= it.ctx;
                        s_deadline_ms <= it.dl;
                        s_now_ms <= it.now;
                        v = 1'b1;
                        gap = $urandom_range(0, 7);
                        if (!tail && gap == 0) idle_left = $urandom_range(1, 16);
                    end
                end
            end
        end
        s_valid <= v;
    end

    // monitor and result-side flow control
    always @(posedge aclk) begin
        timer_result_t e;
        static int stall_left = 0;
        static int long_hold = 0;
        logic r;
        r = 1'b1;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("deadline_timer_queue test failed");
            $finish;
        end
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected item kind=%0d", m_result_kind);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    checked++;
                    if (m_result_kind == KIND_FIRED) fired_seen++;
                    if (m_result_kind !== e.kind) begin
                        $error("result_kind exp %0d got %0d", e.kind, m_result_kind);
                        errors++;
                    end
                    if (m_fired_context !== e.ctx) begin
                        $error("fired_context exp %h got %h", e.ctx, m_fired_context);
                        errors++;
                    end
                    if (m_fired_deadline !== e.dl) begin
                        $error("fired_deadline exp %h got %h", e.dl, m_fired_deadline);
                        errors++;
                    end
                    if (m_last_of_batch !== e.last) begin
                        $error("last_of_batch exp %0d got %0d", e.last, m_last_of_batch);
                        errors++;
                    end
                end
            end
            if (!hold_done && accepted >= 160) begin
                hold_done = 1'b1;
                long_hold = 600;
            end
            if (long_hold > 0) begin
                long_hold--;
                r = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                r = 1'b0;
            end else if (pending_reqs.size() >= 60 && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16);
                r = 1'b0;
            end
        end
        m_ready <= r;
    end

    initial begin
        int kind_pick;
        dl_pool = '{48'd0, 48'd1, 48'd100, 48'd101, 48'd5000, 48'h8000_0000_0000,
                    48'hFFFF_FFFF_FFFE, DL_MAX};
        // directed
        queue_req(REQ_ADD, 32'h0, 48'd0, '0, 0);
        queue_req(REQ_ADD, 32'hFFFF_FFFF, DL_MAX, '0, 0);
        queue_req(REQ_ADD, 32'h1234_5678, 48'd100, '0, 0);
        queue_req(REQ_ADD, 32'hA5A5_5A5A, 48'd100, '0, 0);
        queue_req(REQ_ADD, 32'h0000_0005, 48'd100, '0, 0);
        queue_req(REQ_POLL, '0, '0, 48'd0, 0);
        queue_req(REQ_POLL, '0, '0, 48'd50, 0);
        queue_req(REQ_POLL, '0, '0, 48'd100, 0);
        queue_req(REQ_SPARE, 32'hFFFF_FFFF, DL_MAX, DL_MAX, 0);
        queue_req(REQ_POLL, '0, '0, 48'hFFFF_FFFF_FFFE, 0);
        queue_req(REQ_POLL, '0, '0, DL_MAX, 0);
        queue_req(REQ_POLL, '0, '0, DL_MAX, 0);
        // random
        for (int i = 0; i < 380; i++) begin
            if (i == 120) begin
                // fill past capacity, then drain
                for (int j = 0; j < CAP + 2; j++)
                    queue_req(REQ_ADD, $urandom, rand_time(), '0, 0);
                for (int j = 0; j < 6; j++)
                    queue_req(REQ_POLL, '0, '0, DL_MAX, 0);
            end
            kind_pick = $urandom_range(0, 19);
            if (kind_pick < 11)
                queue_req(REQ_ADD, $urandom, rand_time(), rand_wide(), 0);
            else if (kind_pick < 19)
                queue_req(REQ_POLL, $urandom, rand_wide(), rand_time(), i == 200);
            else
                queue_req(REQ_SPARE, $urandom, rand_wide(), rand_time(), 0);
        end
        // stop phase
        for (int j = 0; j < 6; j++)
            queue_req(REQ_ADD, $urandom, dl_pool[$urandom_range(4, 7)], '0, 0);
        queue_req(REQ_STOP, '0, '0, '0, 1);
        queue_req(REQ_STOP, '0, '0, '0, 0);
        queue_req(REQ_ADD, 32'hFFFF_FFFF, 48'd0, '0, 0);
        for (int j = 0; j < 12; j++)
            queue_req(REQ_POLL, '0, '0, 48'd0, 0);
        queue_req(REQ_SPARE, '0, '0, '0, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Ran %0d requests, %0d results checked (%0d fired entries),",
                 accepted, checked, fired_seen);
        $display("including a full table, grouped deadlines and a post-stop drain.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("deadline_timer_queue test passed");
        end else begin
            $display("deadline_timer_queue test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+design
design/dtq_pkg.sv
design/dtq_datapath.sv
design/dtq_ctrl.sv
design/deadline_timer_queue.sv
verif/tb_top.sv
